FILE: hdl/tgr_pkg.sv
// Shared constants, register indexes and saturating fixed-point helpers.
`timescale 1ns / 1ps
package tgr_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int SIG_GAIN  = 200;
    localparam int MAX_BITS  = 64;
    localparam int XW        = 2 * MAX_BITS + 2;
    localparam int CFG_AW    = 3;

    typedef logic signed [XW-1:0] t_wide;

    typedef enum logic [CFG_AW-1:0] {
        REG_DROOP_INV   = 3'd0,
        REG_POWER_REF   = 3'd1,
        REG_VALVE_LAG   = 3'd2,
        REG_LEAD_TIME   = 3'd3,
        REG_TURB_LAG    = 3'd4,
        REG_DAMPING     = 3'd5,
        REG_VALVE_FLOOR = 3'd6,
        REG_VALVE_CEIL  = 3'd7
    } t_reg_idx;

    // clamp to a w-bit signed range
    function automatic t_wide sat_w(input t_wide v, input int w);
        t_wide mx;
        t_wide mn;
        mx = (t_wide'(1) <<< (w - 1)) - t_wide'(1);
        mn = -mx - t_wide'(1);
        if (v > mx) return mx;
        if (v < mn) return mn;
        return v;
    endfunction

    function automatic t_wide neg_w(input t_wide a, input int w);
        return sat_w(-a, w);
    endfunction

    function automatic t_wide add_w(input t_wide a, input t_wide b, input int w);
        return sat_w(a + b, w);
    endfunction

    // subtract goes through a saturated negate first
    function automatic t_wide sub_w(input t_wide a, input t_wide b, input int w);
        return sat_w(a + neg_w(b, w), w);
    endfunction

    // product, round half away from zero while dropping sh bits, saturate
    function automatic t_wide mulq_w(input t_wide a, input t_wide b, input int w,
                                     input int sh);
        t_wide p;
        t_wide m;
        t_wide half;
        logic  ng;
        p    = a * b;
        ng   = p < 0;
        m    = ng ? -p : p;
        half = (sh > 0) ? (t_wide'(1) <<< (sh - 1)) : t_wide'(0);
        m    = (m + half) >>> sh;
        return sat_w(ng ? -m : m, w);
    endfunction
endpackage

FILE: hdl/tgr_front.sv
// Front stages: droop path, valve rate f, lead term, valve limit differences and the two outer residuals.
`timescale 1ns / 1ps
module tgr_front import tgr_pkg::*; #(
    parameter int W = WORD_BITS,
    parameter int F = FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_omega,
    input  logic signed [W-1:0] i_pv,
    input  logic signed [W-1:0] i_ptx,
    input  logic signed [W-1:0] i_pmech,
    input  logic signed [W-1:0] i_pvdot,
    input  logic signed [W-1:0] i_ptxdot,
    input  logic signed [W-1:0] i_droop,
    input  logic signed [W-1:0] i_pref,
    input  logic signed [W-1:0] i_t1inv,
    input  logic signed [W-1:0] i_t2,
    input  logic signed [W-1:0] i_t3inv,
    input  logic signed [W-1:0] i_dt,
    input  logic signed [W-1:0] i_floor,
    input  logic signed [W-1:0] i_ceil,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [W-1:0] o_f,
    output logic signed [W-1:0] o_dfl,
    output logic signed [W-1:0] o_dce,
    output logic signed [W-1:0] o_pvdot,
    output logic signed [W-1:0] o_r0,
    output logic signed [W-1:0] o_r2
);
    localparam int NS = 4;

    function automatic t_wide wx(input logic signed [W-1:0] v);
        return t_wide'(v);
    endfunction

    function automatic logic signed [W-1:0] nw(input t_wide v);
        return v[W-1:0];
    endfunction

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    logic signed [W-1:0] r_s1_a, r_s1_ltpv, r_s1_damp, r_s1_pv, r_s1_ptx;
    logic signed [W-1:0] r_s1_pmech, r_s1_pvdot, r_s1_ptxdot;
    logic signed [W-1:0] r_s2_b, r_s2_lsum, r_s2_dfl, r_s2_dce, r_s2_pv;
    logic signed [W-1:0] r_s2_pmech, r_s2_damp, r_s2_pvdot, r_s2_ptxdot;
    logic signed [W-1:0] r_s3_c, r_s3_lead, r_s3_dfl, r_s3_dce, r_s3_pv;
    logic signed [W-1:0] r_s3_pmech, r_s3_damp, r_s3_pvdot, r_s3_ptxdot;
    logic signed [W-1:0] r_s4_f, r_s4_r0, r_s4_r2, r_s4_dfl, r_s4_dce, r_s4_pvdot;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_a      <= nw(sub_w(wx(i_pref), wx(i_omega), W));
            r_s1_ltpv   <= nw(mulq_w(wx(i_t2), wx(i_pv), W, F));
            r_s1_damp   <= nw(mulq_w(wx(i_dt), wx(i_omega), W, F));
            r_s1_pv     <= i_pv;
            r_s1_ptx    <= i_ptx;
            r_s1_pmech  <= i_pmech;
            r_s1_pvdot  <= i_pvdot;
            r_s1_ptxdot <= i_ptxdot;
        end
        if (en[1]) begin
            r_s2_b      <= nw(mulq_w(wx(r_s1_a), wx(i_droop), W, F));
            r_s2_lsum   <= nw(add_w(wx(r_s1_ptx), wx(r_s1_ltpv), W));
            r_s2_dfl    <= nw(sub_w(wx(i_floor), wx(r_s1_pv), W));
            r_s2_dce    <= nw(sub_w(wx(r_s1_pv), wx(i_ceil), W));
            r_s2_pv     <= r_s1_pv;
            r_s2_pmech  <= r_s1_pmech;
            r_s2_damp   <= r_s1_damp;
            r_s2_pvdot  <= r_s1_pvdot;
            r_s2_ptxdot <= r_s1_ptxdot;
        end
        if (en[2]) begin
            r_s3_c      <= nw(sub_w(wx(r_s2_pv), wx(r_s2_b), W));
            r_s3_lead   <= nw(mulq_w(wx(r_s2_lsum), wx(i_t3inv), W, F));
            r_s3_dfl    <= r_s2_dfl;
            r_s3_dce    <= r_s2_dce;
            r_s3_pv     <= r_s2_pv;
            r_s3_pmech  <= r_s2_pmech;
            r_s3_damp   <= r_s2_damp;
            r_s3_pvdot  <= r_s2_pvdot;
            r_s3_ptxdot <= r_s2_ptxdot;
        end
        if (en[3]) begin
            r_s4_f     <= nw(mulq_w(wx(r_s3_c), wx(i_t1inv), W, F));
            r_s4_r0    <= nw(add_w(sub_w(wx(r_s3_ptxdot), wx(r_s3_pv), W),
                                   wx(r_s3_lead), W));
            r_s4_r2    <= nw(sub_w(sub_w(wx(r_s3_pmech), wx(r_s3_lead), W),
                                   wx(r_s3_damp), W));
            r_s4_dfl   <= r_s3_dfl;
            r_s4_dce   <= r_s3_dce;
            r_s4_pvdot <= r_s3_pvdot;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_f     = r_s4_f;
    assign o_dfl   = r_s4_dfl;
    assign o_dce   = r_s4_dce;
    assign o_pvdot = r_s4_pvdot;
    assign o_r0    = r_s4_r0;
    assign o_r2    = r_s4_r2;
endmodule

FILE: hdl/tgr_sigdiv.sv
// Four-lane sigmoid: gain and magnitude, pipelined restoring divide, sign select.
`timescale 1ns / 1ps
module tgr_sigdiv import tgr_pkg::*; #(
    parameter int W  = WORD_BITS,
    parameter int F  = FRAC_BITS,
    parameter int SW = 4 * W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_x [4],
    input  logic                i_neg1,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [W-1:0] o_s [4],
    output logic [SW-1:0]       o_side
);
    localparam int NS = F + 2;
    localparam int RW = W + F + 2;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    logic [RW-1:0]       r_rem  [NS-1][4];
    logic [RW-1:0]       r_den  [NS-1][4];
    logic [F-1:0]        r_q    [NS-1][4];
    logic [3:0]          r_sg   [NS-1];
    logic [SW-1:0]       r_side [NS];
    logic signed [W-1:0] r_s    [4];

    always_ff @(posedge i_clk) begin
        t_wide xw;
        t_wide ax;
        t_wide u;
        logic [RW-1:0] t;
        // prep: a*x saturated, den = 1 + |a*x|
        if (en[0]) begin
            for (int l = 0; l < 4; l++) begin
                xw = t_wide'(i_x[l]);
                if (l == 1 && i_neg1) xw = neg_w(xw, W);
                ax = mulq_w(xw, t_wide'(SIG_GAIN), W, 0);
                u  = (ax < 0) ? -ax : ax;
                r_sg[0][l]  <= ax < 0;
                r_den[0][l] <= RW'(u) + (RW'(1) << F);
                r_rem[0][l] <= RW'(1) << (2 * F - 1);
                r_q[0][l]   <= '0;
            end
            r_side[0] <= i_side;
        end
        // one quotient bit per stage, msb first
        for (int k = 1; k <= F; k++) begin
            if (en[k]) begin
                for (int l = 0; l < 4; l++) begin
                    t = r_den[k-1][l] << (F - k);
                    if (r_rem[k-1][l] >= t) begin
                        r_rem[k][l]       <= r_rem[k-1][l] - t;
                        r_q[k][l]         <= r_q[k-1][l] | (F'(1) << (F - k));
                    end else begin
                        r_rem[k][l]       <= r_rem[k-1][l];
                        r_q[k][l]         <= r_q[k-1][l];
                    end
                    r_den[k][l] <= r_den[k-1][l];
                end
                r_sg[k]   <= r_sg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
        if (en[NS-1]) begin
            for (int l = 0; l < 4; l++) begin
                r_s[l] <= r_sg[F][l] ? W'(r_q[F][l])
                                     : (W'(1) << F) - W'(r_q[F][l]);
            end
            r_side[NS-1] <= r_side[NS-2];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_s     = r_s;
    assign o_side  = r_side[NS-1];
endmodule

FILE: hdl/tgr_back.sv
// Back stages: limit indicator product, valve residual and the output register.
`timescale 1ns / 1ps
module tgr_back import tgr_pkg::*; #(
    parameter int W = WORD_BITS,
    parameter int F = FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_s [4],
    input  logic signed [W-1:0] i_f,
    input  logic signed [W-1:0] i_pvdot,
    input  logic signed [W-1:0] i_r0,
    input  logic signed [W-1:0] i_r2,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [W-1:0] o_r0,
    output logic signed [W-1:0] o_r1,
    output logic signed [W-1:0] o_r2
);
    localparam int NS = 4;

    function automatic t_wide wx(input logic signed [W-1:0] v);
        return t_wide'(v);
    endfunction

    function automatic logic signed [W-1:0] nw(input t_wide v);
        return v[W-1:0];
    endfunction

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    logic signed [W-1:0] r_b1_low, r_b1_high, r_b2_ind, r_b3_m;
    logic signed [W-1:0] r_f [2];
    logic signed [W-1:0] r_pvdot [3];
    logic signed [W-1:0] r_r0 [4];
    logic signed [W-1:0] r_r2 [4];
    logic signed [W-1:0] r_r1;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_b1_low   <= nw(mulq_w(wx(i_s[0]), wx(i_s[1]), W, F));
            r_b1_high  <= nw(mulq_w(wx(i_s[2]), wx(i_s[3]), W, F));
            r_f[0]     <= i_f;
            r_pvdot[0] <= i_pvdot;
            r_r0[0]    <= i_r0;
            r_r2[0]    <= i_r2;
        end
        if (en[1]) begin
            r_b2_ind   <= nw(mulq_w(sub_w(t_wide'(1) <<< F, wx(r_b1_low), W),
                                    sub_w(t_wide'(1) <<< F, wx(r_b1_high), W), W, F));
            r_f[1]     <= r_f[0];
            r_pvdot[1] <= r_pvdot[0];
            r_r0[1]    <= r_r0[0];
            r_r2[1]    <= r_r2[0];
        end
        if (en[2]) begin
            r_b3_m     <= nw(mulq_w(wx(r_b2_ind), wx(r_f[1]), W, F));
            r_pvdot[2] <= r_pvdot[1];
            r_r0[2]    <= r_r0[1];
            r_r2[2]    <= r_r2[1];
        end
        if (en[3]) begin
            r_r1    <= nw(add_w(wx(r_pvdot[2]), wx(r_b3_m), W));
            r_r0[3] <= r_r0[2];
            r_r2[3] <= r_r2[2];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_r0    = r_r0[3];
    assign o_r1    = r_r1;
    assign o_r2    = r_r2[3];
endmodule

FILE: hdl/turbine_governor_residual_top.sv
// Top level of the TGOV1 governor residual pipeline with its register file.
//
// Channels: slave stream (i_s_tvalid/o_s_tready/i_s_tdata) takes one operating
// point per word; master stream (o_m_tvalid/i_m_tready/o_m_tdata) returns the
// three residuals per word. Words move when tvalid and tready are both high.
// Configuration: i_cfg_wen writes i_cfg_data into register i_cfg_addr at once;
// write only while no word is in flight.
// Stages of the Q16.16 datapath: 4 front stages, 1 sigmoid prep stage,
// FRAC_BITS divide stages (one quotient bit each, four lanes side by side),
// 1 sign-select stage, 4 back stages.
// Throughput: one word per cycle unless stalled. Every stage has its own valid
// bit and loads when it is empty or the stage after it moves, so bubbles close
// up and input keeps flowing while a result waits in the output register.
// Stall: when i_m_tready is low the result holds; the stages fill up and
// o_s_tready drops only once every stage is occupied. Nothing is lost or
// repeated.
// Reset (i_rst_n low, synchronous): all valid bits clear, registers return to
// their defaults (1/R = 20, Pref = 0.05, 1/T1 = 2, T2 = 1, 1/T3 = 1, Dt = 0,
// Pvmin = 0, Pvmax = 1).
`timescale 1ns / 1ps
module turbine_governor_residual_top import tgr_pkg::*; #(
    parameter int WORD_BITS_P = WORD_BITS,
    parameter int FRAC_BITS_P = FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // shaft_speed, valve_position, turbine_state, mech_power, valve_rate,
    // turbine_rate, zero pad
    input  logic [((6 * WORD_BITS_P + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // turbine_residual, valve_residual, power_residual, zero pad
    output logic [((3 * WORD_BITS_P + 7) / 8) * 8 - 1:0] o_m_tdata,
    input  logic                     i_cfg_wen,
    input  logic [CFG_AW-1:0]        i_cfg_addr,
    input  logic [WORD_BITS_P-1:0]   i_cfg_data
);
    localparam int W   = WORD_BITS_P;
    localparam int F   = FRAC_BITS_P;
    localparam int ODW = ((3 * W + 7) / 8) * 8;

    // register file; the unsigned reciprocals keep their top bit at zero
    logic signed [W-1:0] r_droop, r_pref, r_t1inv, r_t2, r_t3inv, r_dt, r_floor, r_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_droop <= W'(1310720);
            r_pref  <= W'(3277);
            r_t1inv <= W'(131072);
            r_t2    <= W'(65536);
            r_t3inv <= W'(65536);
            r_dt    <= '0;
            r_floor <= '0;
            r_ceil  <= W'(65536);
        end else if (i_cfg_wen) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_DROOP_INV:   r_droop <= {1'b0, i_cfg_data[W-2:0]};
                REG_POWER_REF:   r_pref  <= i_cfg_data;
                REG_VALVE_LAG:   r_t1inv <= {1'b0, i_cfg_data[W-2:0]};
                REG_LEAD_TIME:   r_t2    <= i_cfg_data;
                REG_TURB_LAG:    r_t3inv <= {1'b0, i_cfg_data[W-2:0]};
                REG_DAMPING:     r_dt    <= i_cfg_data;
                REG_VALVE_FLOOR: r_floor <= i_cfg_data;
                REG_VALVE_CEIL:  r_ceil  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                fr_valid, dv_ready, dv_valid, bk_ready;
    logic signed [W-1:0] fr_f, fr_dfl, fr_dce, fr_pvdot, fr_r0, fr_r2;
    logic signed [W-1:0] dv_x [4];
    logic signed [W-1:0] dv_s [4];
    logic [4*W-1:0]      dv_side_in, dv_side_out;
    logic signed [W-1:0] o_r0, o_r1, o_r2;

    tgr_front #(.W(W), .F(F)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_omega  (i_s_tdata[W-1:0]),
        .i_pv     (i_s_tdata[2*W-1:W]),
        .i_ptx    (i_s_tdata[3*W-1:2*W]),
        .i_pmech  (i_s_tdata[4*W-1:3*W]),
        .i_pvdot  (i_s_tdata[5*W-1:4*W]),
        .i_ptxdot (i_s_tdata[6*W-1:5*W]),
        .i_droop  (r_droop),
        .i_pref   (r_pref),
        .i_t1inv  (r_t1inv),
        .i_t2     (r_t2),
        .i_t3inv  (r_t3inv),
        .i_dt     (r_dt),
        .i_floor  (r_floor),
        .i_ceil   (r_ceil),
        .o_valid  (fr_valid),
        .i_ready  (dv_ready),
        .o_f      (fr_f),
        .o_dfl    (fr_dfl),
        .o_dce    (fr_dce),
        .o_pvdot  (fr_pvdot),
        .o_r0     (fr_r0),
        .o_r2     (fr_r2)
    );

    // lanes: s(floor-pv), s(-f), s(pv-ceiling), s(f); lane 1 negates inside
    assign dv_x[0]    = fr_dfl;
    assign dv_x[1]    = fr_f;
    assign dv_x[2]    = fr_dce;
    assign dv_x[3]    = fr_f;
    assign dv_side_in = {fr_r2, fr_r0, fr_pvdot, fr_f};

    tgr_sigdiv #(.W(W), .F(F), .SW(4 * W)) u_sigdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (dv_ready),
        .i_x     (dv_x),
        .i_neg1  (1'b1),
        .i_side  (dv_side_in),
        .o_valid (dv_valid),
        .i_ready (bk_ready),
        .o_s     (dv_s),
        .o_side  (dv_side_out)
    );

    tgr_back #(.W(W), .F(F)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_valid),
        .o_ready (bk_ready),
        .i_s     (dv_s),
        .i_f     (dv_side_out[W-1:0]),
        .i_pvdot (dv_side_out[2*W-1:W]),
        .i_r0    (dv_side_out[3*W-1:2*W]),
        .i_r2    (dv_side_out[4*W-1:3*W]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_r0    (o_r0),
        .o_r1    (o_r1),
        .o_r2    (o_r2)
    );

    assign o_m_tdata = ODW'({o_r2, o_r1, o_r0});

    // pipeline with an empty output register can never refuse input
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output stage");

    // reset flushes the result register
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // reciprocal registers are unsigned
    a_recip_unsigned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_droop[W-1] && !r_t1inv[W-1] && !r_t3inv[W-1])
        else $error("reciprocal register went negative");
endmodule

FILE: tb/sv/tb_turbine_governor_residual_top.sv
// Self-checking testbench for the TGOV1 governor residual pipeline.
`timescale 1ns / 1ps
module tb_turbine_governor_residual_top;
    import tgr_pkg::*;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam longint ONE_Q = 64'sd65536;
    localparam int     DRAIN_CYCLES = 40;   // pipeline is 26 deep, plus margin

    typedef struct {
        logic signed [31:0] omega, pv, ptx, pmech, pv_dot, ptx_dot;
    } t_point;

    typedef struct {
        logic signed [31:0] turb, valve, power;
    } t_resid;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    // shaft_speed, valve_position, turbine_state, mech_power, valve_rate, turbine_rate
    logic [191:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // turbine_residual, valve_residual, power_residual
    logic [95:0]  o_m_tdata;
    logic         i_cfg_wen = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_data = '0;

    turbine_governor_residual_top i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // local copy of the register file
    longint droop_inv, p_ref, valve_lag, lead_t, turb_lag, damp, v_floor, v_ceil;

    t_resid resid_q[$];
    int     err_cnt = 0;
    int     burst_left = 0;
    int     stall_pct = 0;
    int     stall_age = 0;

    // ---------------- fixed-point model ----------------
    function automatic longint q_sat(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function automatic longint q_add(longint a, longint b);
        return q_sat(a + b);
    endfunction

    function automatic longint q_neg(longint a);
        return q_sat(-a);
    endfunction

    // subtract saturates the negated operand first (so x - MIN = x + MAX)
    function automatic longint q_sub(longint a, longint b);
        return q_add(a, q_neg(b));
    endfunction

    function automatic longint q_mul(longint a, longint b, int sh);
        longint p, m;
        p = a * b;
        m = (p < 0) ? -p : p;
        if (sh > 0) m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return q_sat((p < 0) ? -m : m);
    endfunction

    // rational sigmoid, gain 200, exact 0.5 at zero
    function automatic longint q_sigmoid(longint x);
        longint ax, u, h;
        ax = q_mul(x, 200, 0);
        u  = (ax < 0) ? -ax : ax;
        h  = (64'sd1 <<< 31) / (ONE_Q + u);
        return (ax < 0) ? h : ONE_Q - h;
    endfunction

    function automatic t_resid governor_residuals(t_point p);
        longint f, lo, hi, ind, lead;
        t_resid r;
        f    = q_mul(q_sub(p.pv, q_mul(q_sub(p_ref, p.omega), droop_inv, 16)),
                     valve_lag, 16);
        lo   = q_mul(q_sigmoid(q_sub(v_floor, p.pv)), q_sigmoid(q_neg(f)), 16);
        hi   = q_mul(q_sigmoid(q_sub(p.pv, v_ceil)), q_sigmoid(f), 16);
        ind  = q_mul(q_sub(ONE_Q, lo), q_sub(ONE_Q, hi), 16);
        lead = q_mul(q_add(p.ptx, q_mul(lead_t, p.pv, 16)), turb_lag, 16);
        r.turb  = 32'(q_add(q_sub(p.ptx_dot, p.pv), lead));
        r.valve = 32'(q_add(p.pv_dot, q_mul(ind, f, 16)));
        r.power = 32'(q_sub(q_sub(p.pmech, lead), q_mul(damp, p.omega, 16)));
        return r;
    endfunction

    // ---------------- receiver: random stalls at a changing share ----------------
    always @(posedge i_clk) begin
        stall_age <= stall_age + 1;
        if (stall_age % 150 == 0)
            stall_pct <= $urandom_range(0, 3) * 25;   // 0 gives stall-free stretches
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_resid want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (resid_q.size() == 0) begin
                $error("unexpected result word %h", o_m_tdata);
                err_cnt++;
            end else begin
                want = resid_q.pop_front();
                if (o_m_tdata[31:0] !== want.turb) begin
                    $error("turbine_residual exp %h got %h", want.turb, o_m_tdata[31:0]);
                    err_cnt++;
                end
                if (o_m_tdata[63:32] !== want.valve) begin
                    $error("valve_residual exp %h got %h", want.valve, o_m_tdata[63:32]);
                    err_cnt++;
                end
                if (o_m_tdata[95:64] !== want.power) begin
                    $error("power_residual exp %h got %h", want.power, o_m_tdata[95:64]);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------- sender ----------------
    // called and returns on a rising edge; valid stays high across a burst
    task automatic send_point(t_point p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {p.ptx_dot, p.pv_dot, p.pmech, p.ptx, p.pv, p.omega};
        do @(posedge i_clk); while (!o_s_tready);
        resid_q.push_back(governor_residuals(p));
        burst_left--;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        wait (resid_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        wait_drained();
        i_cfg_wen  <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            REG_DROOP_INV:   droop_inv = longint'(v[30:0]);
            REG_POWER_REF:   p_ref     = longint'($signed(v));
            REG_VALVE_LAG:   valve_lag = longint'(v[30:0]);
            REG_LEAD_TIME:   lead_t    = longint'($signed(v));
            REG_TURB_LAG:    turb_lag  = longint'(v[30:0]);
            REG_DAMPING:     damp      = longint'($signed(v));
            REG_VALVE_FLOOR: v_floor   = longint'($signed(v));
            REG_VALVE_CEIL:  v_ceil    = longint'($signed(v));
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_field(bit near);
        if (near) return $urandom_range(0, 262143) - 131072;   // +-2.0, sigmoid live
        return $urandom;
    endfunction

    function automatic t_point rand_point(bit near);
        t_point p;
        p.omega   = rand_field(near);
        p.pv      = rand_field(near);
        p.ptx     = rand_field(near);
        p.pmech   = rand_field(near);
        p.pv_dot  = rand_field(near);
        p.ptx_dot = rand_field(near);
        return p;
    endfunction

    function automatic t_point fill_point(logic [31:0] v);
        t_point p;
        p.omega = v; p.pv = v; p.ptx = v; p.pmech = v; p.pv_dot = v; p.ptx_dot = v;
        return p;
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        t_point p;
        send_point(fill_point(32'h0));
        send_point(fill_point(32'h7FFFFFFF));
        send_point(fill_point(32'h80000000));
        send_point(fill_point(32'hFFFFFFFF));
        send_point(fill_point(32'h00010000));
        // valve exactly at floor and at ceiling, with f = 0 and f either sign
        p = fill_point(32'h0);
        p.omega = 32'h00000CCD;                 // omega = Pref -> f = pv * 2
        send_point(p);
        p.pv = 32'h00010000;
        send_point(p);
        p.omega = 32'h80000000;                 // Pref - MIN saturates
        send_point(p);
        p.omega = 32'h7FFFFFFF;
        p.pv = 32'h80000000;                    // negate of most negative
        send_point(p);
        p = fill_point(32'h0);
        p.pv = 32'h00008000; p.ptx = 32'h7FFFFFFF; p.pmech = 32'h80000000;
        send_point(p);
        p.pv = 32'hFFFF0001; p.pv_dot = 32'h7FFFFFFF; p.ptx_dot = 32'h80000000;
        send_point(p);
        for (int i = 0; i < 8; i++) send_point(rand_point(1'b1));
    endtask

    task automatic test_register_extremes();
        t_reg_idx idx;
        // upper bit of unsigned registers must be dropped
        write_reg(REG_DROOP_INV, 32'hFFFFFFFF);
        write_reg(REG_VALVE_LAG, 32'hFFFFFFFF);
        write_reg(REG_TURB_LAG, 32'hFFFFFFFF);
        write_reg(REG_POWER_REF, 32'h80000000);
        write_reg(REG_LEAD_TIME, 32'h7FFFFFFF);
        write_reg(REG_DAMPING, 32'h80000000);
        write_reg(REG_VALVE_FLOOR, 32'h7FFFFFFF);   // floor above ceiling
        write_reg(REG_VALVE_CEIL, 32'h80000000);
        for (int i = 0; i < 40; i++) send_point(rand_point(i[0]));
        write_reg(REG_DROOP_INV, 32'h0);
        write_reg(REG_VALVE_LAG, 32'h0);
        write_reg(REG_TURB_LAG, 32'h0);
        write_reg(REG_POWER_REF, 32'h7FFFFFFF);
        write_reg(REG_LEAD_TIME, 32'h80000000);
        write_reg(REG_DAMPING, 32'h7FFFFFFF);
        write_reg(REG_VALVE_FLOOR, 32'h80000000);
        write_reg(REG_VALVE_CEIL, 32'h7FFFFFFF);
        for (int i = 0; i < 40; i++) send_point(rand_point(i[0]));
        for (int r = 0; r < 8; r++) begin
            idx = t_reg_idx'(r);
            write_reg(idx, $urandom);
        end
        for (int i = 0; i < 40; i++) send_point(rand_point(i[0]));
    endtask

    // typical governor settings with random content; mostly in the live band
    task automatic test_random_points();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_DROOP_INV, $urandom_range(65536, 1966080));
            write_reg(REG_POWER_REF, $urandom_range(0, 131072) - 32768);
            write_reg(REG_VALVE_LAG, $urandom_range(6554, 655360));
            write_reg(REG_LEAD_TIME, $urandom_range(0, 196608) - 65536);
            write_reg(REG_TURB_LAG, $urandom_range(6554, 655360));
            write_reg(REG_DAMPING, $urandom_range(0, 131072) - 65536);
            write_reg(REG_VALVE_FLOOR, $urandom_range(0, 32768) - 16384);
            write_reg(REG_VALVE_CEIL, $urandom_range(49152, 81920));
            for (int i = 0; i < 213; i++)
                send_point(rand_point($urandom_range(0, 3) != 0));
        end
    endtask

    // sender holds off until every result is back, then restarts
    task automatic test_drain_restart();
        for (int i = 0; i < 30; i++) send_point(rand_point(1'b1));
        wait_drained();
        for (int i = 0; i < 30; i++) send_point(rand_point(1'b0));
    endtask

    initial begin
        droop_inv = 1310720; p_ref = 3277; valve_lag = 131072; lead_t = 65536;
        turb_lag = 65536; damp = 0; v_floor = 0; v_ceil = 65536;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drain_restart();
        test_register_extremes();
        test_random_points();
        wait_drained();
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
